@@ design/rrts_pkg.sv @@
// rrts_pkg: types, codes and default sizes of the round-robin thread scheduler
// no dependencies; used by rrts_ctrl, rrts_datapath and the top module
package rrts_pkg;

    localparam int SLOT_COUNT_DEF  = 16;
    localparam int QUEUE_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        CMD_CREATE, CMD_YIELD_ANY, CMD_YIELD_TO, CMD_EXIT,
        CMD_KILL, CMD_SLEEP, CMD_WAKE_ONE, CMD_WAKE_ALL
    } cmd_t;

    typedef enum logic [2:0] {
        ST_EMPTY, ST_RUNNING, ST_READY, ST_SLEEPING, ST_KILLED
    } status_t;

    typedef enum logic [2:0] {
        RC_OK, RC_INVALID, RC_NONE, RC_NOSLOT, RC_FULL
    } rc_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_WTEST, S_WDATA, S_WEND, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_STEP, OP_FOUND, OP_NOTFOUND, OP_TARGET,
        OP_INVALID, OP_POP, OP_WAKE, OP_WAKE_END
    } op_t;

    typedef enum logic [1:0] {
        RS_SCAN, RS_TGT, RS_MEM
    } rsel_t;

    typedef struct packed {
        op_t   op;
        rsel_t rsel;
        logic  out_load;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic qs_ok;
        logic scan_hit;
        logic scan_last;
        logic q_empty;
        logic wake_hit;
    } stat_t;

endpackage

@@ design/rrts_req_if.sv @@
// rrts_req_if: request channel of the scheduler (command, target, queue)
// depends on nothing
interface rrts_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] target_slot;
    logic [2:0] queue_select;

    modport source (output valid, command, target_slot, queue_select, input ready);
    modport sink (input valid, command, target_slot, queue_select, output ready);
endinterface

@@ design/rrts_rsp_if.sv @@
// rrts_rsp_if: result channel of the scheduler
// depends on nothing
interface rrts_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_code;
    logic [3:0] result_slot;
    logic [4:0] woken_count;
    logic [3:0] running_slot;

    modport source (output valid, result_code, result_slot, woken_count, running_slot,
                    input ready);
    modport sink (input valid, result_code, result_slot, woken_count, running_slot,
                  output ready);
endinterface

@@ design/round_robin_thread_state_scheduler_top.sv @@
// round_robin_thread_state_scheduler_top: round-robin thread scheduler
// depends on rrts_pkg, rrts_req_if, rrts_rsp_if, rrts_ctrl, rrts_datapath
//
//   channel  dir  fields
//   req      in   command, target_slot, queue_select
//   rsp      out  result_code, result_slot, woken_count, running_slot
//
// one request at a time: accept, dispatch, then the command's own work, then the
// result moves into the output register
// create/yield_any/exit/sleep: scan of up to SLOT_COUNT slots, one slot per cycle
// wake: a pop state and a wake state per popped queue entry, then an end state
// yield_to, kill and sleep/wake with an invalid queue: dispatch, then output
// rsp stall holds the result; req is taken again once it has moved out
module round_robin_thread_state_scheduler_top #(
    parameter int SLOT_COUNT  = rrts_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_COUNT = rrts_pkg::QUEUE_COUNT_DEF,
    parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    rrts_req_if.sink   req,
    rrts_rsp_if.source rsp
);

    rrts_pkg::ctrl_t ctrl;
    rrts_pkg::stat_t stat;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    rrts_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .QUEUE_COUNT (QUEUE_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (req.command),
        .target_slot  (req.target_slot),
        .queue_select (req.queue_select),
        .ctrl         (ctrl),
        .stat         (stat),
        .result_code  (rsp.result_code),
        .result_slot  (rsp.result_slot),
        .woken_count  (rsp.woken_count),
        .running_slot (rsp.running_slot)
    );

endmodule

@@ design/rrts_ctrl.sv @@
// rrts_ctrl: command sequencer of the scheduler
// depends on rrts_pkg
module rrts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  rrts_pkg::stat_t stat,
    output rrts_pkg::ctrl_t ctrl
);

    rrts_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrts_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrts_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = rrts_pkg::S_DISPATCH;
            end
            rrts_pkg::S_DISPATCH:
            begin
                unique case (stat.cmd)
                    rrts_pkg::CMD_CREATE, rrts_pkg::CMD_YIELD_ANY, rrts_pkg::CMD_EXIT:
                        state_next = rrts_pkg::S_SCAN;
                    rrts_pkg::CMD_SLEEP:
                        state_next = stat.qs_ok ? rrts_pkg::S_SCAN : rrts_pkg::S_OUT;
                    rrts_pkg::CMD_YIELD_TO, rrts_pkg::CMD_KILL:
                        state_next = rrts_pkg::S_OUT;
                    rrts_pkg::CMD_WAKE_ONE, rrts_pkg::CMD_WAKE_ALL:
                        state_next = stat.qs_ok ? rrts_pkg::S_WTEST : rrts_pkg::S_OUT;
                    default:
                        state_next = rrts_pkg::S_OUT;
                endcase
            end
            rrts_pkg::S_SCAN:
            begin
                if (stat.scan_hit || stat.scan_last)
                    state_next = rrts_pkg::S_OUT;
            end
            rrts_pkg::S_WTEST:
            begin
                state_next = stat.q_empty ? rrts_pkg::S_WEND : rrts_pkg::S_WDATA;
            end
            rrts_pkg::S_WDATA:
            begin
                if (stat.wake_hit && stat.cmd == rrts_pkg::CMD_WAKE_ONE)
                    state_next = rrts_pkg::S_WEND;
                else
                    state_next = rrts_pkg::S_WTEST;
            end
            rrts_pkg::S_WEND:
                state_next = rrts_pkg::S_OUT;
            rrts_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = rrts_pkg::S_IDLE;
            end
            default:
                state_next = rrts_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.op       = rrts_pkg::OP_NONE;
        ctrl.rsel     = rrts_pkg::RS_SCAN;
        ctrl.out_load = 1'b0;
        in_ready      = 1'b0;
        unique case (state_reg)
            rrts_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    ctrl.op = rrts_pkg::OP_LOAD;
            end
            rrts_pkg::S_DISPATCH:
            begin
                ctrl.rsel = rrts_pkg::RS_TGT;
                unique case (stat.cmd)
                    rrts_pkg::CMD_YIELD_TO, rrts_pkg::CMD_KILL:
                        ctrl.op = rrts_pkg::OP_TARGET;
                    rrts_pkg::CMD_SLEEP, rrts_pkg::CMD_WAKE_ONE, rrts_pkg::CMD_WAKE_ALL:
                        ctrl.op = stat.qs_ok ? rrts_pkg::OP_NONE : rrts_pkg::OP_INVALID;
                    default:
                        ctrl.op = rrts_pkg::OP_NONE;
                endcase
            end
            rrts_pkg::S_SCAN:
            begin
                if (stat.scan_hit)
                    ctrl.op = rrts_pkg::OP_FOUND;
                else if (stat.scan_last)
                    ctrl.op = rrts_pkg::OP_NOTFOUND;
                else
                    ctrl.op = rrts_pkg::OP_STEP;
            end
            rrts_pkg::S_WTEST:
            begin
                if (!stat.q_empty)
                    ctrl.op = rrts_pkg::OP_POP;
            end
            rrts_pkg::S_WDATA:
            begin
                ctrl.rsel = rrts_pkg::RS_MEM;
                ctrl.op   = rrts_pkg::OP_WAKE;
            end
            rrts_pkg::S_WEND:
                ctrl.op = rrts_pkg::OP_WAKE_END;
            rrts_pkg::S_OUT:
                ctrl.out_load = !out_valid_reg || out_ready;
            default:
                ctrl.op = rrts_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        if (ctrl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/rrts_datapath.sv @@
// rrts_datapath: slot status table, running slot, wait queues and result registers
// depends on rrts_pkg
module rrts_datapath #(
    parameter int SLOT_COUNT  = rrts_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_COUNT = rrts_pkg::QUEUE_COUNT_DEF,
    parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      command,
    input  logic [7:0]      target_slot,
    input  logic [2:0]      queue_select,
    input  rrts_pkg::ctrl_t ctrl,
    output rrts_pkg::stat_t stat,
    output logic [2:0]      result_code,
    output logic [3:0]      result_slot,
    output logic [4:0]      woken_count,
    output logic [3:0]      running_slot
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (QUEUE_COUNT * QUEUE_DEPTH > 1) ? $clog2(QUEUE_COUNT * QUEUE_DEPTH) : 1;
    localparam int MD = QUEUE_COUNT * QUEUE_DEPTH;

    rrts_pkg::status_t status_reg [SLOT_COUNT];
    logic [SW-1:0]     cur_reg;
    logic [HW-1:0]     head_reg [QUEUE_COUNT];
    logic [HW-1:0]     tail_reg [QUEUE_COUNT];
    logic [FW-1:0]     fill_reg [QUEUE_COUNT];
    logic [SW-1:0]     mem [MD];
    logic [SW-1:0]     mem_q_reg;

    rrts_pkg::cmd_t    cmd_reg;
    logic [7:0]        tgt_reg;
    logic [2:0]        qs_reg;
    logic [SW-1:0]     n_reg;
    logic [FW-1:0]     woken_reg;
    rrts_pkg::rc_t     res_code_reg;
    logic [SW-1:0]     res_slot_reg;

    logic [2:0]        out_code_reg;
    logic [3:0]        out_slot_reg;
    logic [4:0]        out_woken_reg;
    logic [3:0]        out_run_reg;

    logic [SW:0]       scan_sum;
    logic [SW-1:0]     scan_idx;
    logic [SW-1:0]     rd_idx;
    rrts_pkg::status_t st_rd;
    logic [QW-1:0]     qidx;
    logic [AW-1:0]     head_addr;
    logic [AW-1:0]     tail_addr;
    logic              tgt_ok;
    logic              tgt_is_cur;
    logic              q_full;
    logic              mem_we;

    assign qidx     = QW'(qs_reg);
    assign scan_sum = (SW+1)'(cur_reg) + (SW+1)'(n_reg) + (SW+1)'(1);

    always_comb
    begin
        if (cmd_reg == rrts_pkg::CMD_CREATE)
            scan_idx = n_reg;
        else if (int'(scan_sum) >= SLOT_COUNT)
            scan_idx = SW'(int'(scan_sum) - SLOT_COUNT);
        else
            scan_idx = SW'(scan_sum);
    end

    always_comb
    begin
        unique case (ctrl.rsel)
            rrts_pkg::RS_TGT: rd_idx = SW'(tgt_reg);
            rrts_pkg::RS_MEM: rd_idx = mem_q_reg;
            default:          rd_idx = scan_idx;
        endcase
    end

    assign st_rd      = (int'(rd_idx) < SLOT_COUNT) ? status_reg[rd_idx] : rrts_pkg::ST_EMPTY;
    assign tgt_ok     = int'(tgt_reg) < SLOT_COUNT;
    assign tgt_is_cur = tgt_reg == 8'(cur_reg);
    assign q_full     = fill_reg[qidx] == FW'(QUEUE_DEPTH);
    assign head_addr  = AW'(int'(qidx) * QUEUE_DEPTH + int'(head_reg[qidx]));
    assign tail_addr  = AW'(int'(qidx) * QUEUE_DEPTH + int'(tail_reg[qidx]));
    assign mem_we     = ctrl.op == rrts_pkg::OP_FOUND && cmd_reg == rrts_pkg::CMD_SLEEP
                        && !q_full;

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.qs_ok     = int'(qs_reg) < QUEUE_COUNT;
        stat.scan_hit  = (cmd_reg == rrts_pkg::CMD_CREATE) ? (st_rd == rrts_pkg::ST_EMPTY)
                                                           : (st_rd == rrts_pkg::ST_READY);
        stat.scan_last = int'(n_reg) == SLOT_COUNT - 1;
        stat.q_empty   = fill_reg[qidx] == '0;
        stat.wake_hit  = st_rd == rrts_pkg::ST_SLEEPING;
    end

    // queue entry store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tail_addr] <= cur_reg;
        if (ctrl.op == rrts_pkg::OP_POP)
            mem_q_reg <= mem[head_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                status_reg[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_EMPTY;
            for (int q = 0; q < QUEUE_COUNT; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                fill_reg[q] <= '0;
            end
            cur_reg <= '0;
        end
        else
        begin
            unique case (ctrl.op)
                rrts_pkg::OP_FOUND:
                begin
                    unique case (cmd_reg)
                        rrts_pkg::CMD_CREATE:
                            status_reg[scan_idx] <= rrts_pkg::ST_READY;
                        rrts_pkg::CMD_YIELD_ANY:
                        begin
                            for (int i = 0; i < SLOT_COUNT; i++)
                                if (status_reg[i] == rrts_pkg::ST_KILLED)
                                    status_reg[i] <= rrts_pkg::ST_EMPTY;
                            status_reg[cur_reg]  <= rrts_pkg::ST_READY;
                            status_reg[scan_idx] <= rrts_pkg::ST_RUNNING;
                            cur_reg              <= scan_idx;
                        end
                        rrts_pkg::CMD_EXIT:
                        begin
                            status_reg[cur_reg]  <= rrts_pkg::ST_KILLED;
                            status_reg[scan_idx] <= rrts_pkg::ST_RUNNING;
                            cur_reg              <= scan_idx;
                        end
                        rrts_pkg::CMD_SLEEP:
                        begin
                            if (!q_full)
                            begin
                                tail_reg[qidx] <= (int'(tail_reg[qidx]) == QUEUE_DEPTH - 1)
                                                  ? '0 : tail_reg[qidx] + HW'(1);
                                fill_reg[qidx]       <= fill_reg[qidx] + FW'(1);
                                status_reg[cur_reg]  <= rrts_pkg::ST_SLEEPING;
                                status_reg[scan_idx] <= rrts_pkg::ST_RUNNING;
                                cur_reg              <= scan_idx;
                            end
                        end
                        default:
                            cur_reg <= cur_reg;
                    endcase
                end
                rrts_pkg::OP_TARGET:
                begin
                    if (cmd_reg == rrts_pkg::CMD_YIELD_TO)
                    begin
                        if (!tgt_is_cur && tgt_ok && st_rd == rrts_pkg::ST_READY)
                        begin
                            for (int i = 0; i < SLOT_COUNT; i++)
                                if (status_reg[i] == rrts_pkg::ST_KILLED)
                                    status_reg[i] <= rrts_pkg::ST_EMPTY;
                            status_reg[cur_reg] <= rrts_pkg::ST_READY;
                            status_reg[rd_idx]  <= rrts_pkg::ST_RUNNING;
                            cur_reg             <= rd_idx;
                        end
                    end
                    else if (tgt_ok && st_rd != rrts_pkg::ST_EMPTY && !tgt_is_cur)
                        status_reg[rd_idx] <= rrts_pkg::ST_EMPTY;
                end
                rrts_pkg::OP_POP:
                begin
                    head_reg[qidx] <= (int'(head_reg[qidx]) == QUEUE_DEPTH - 1)
                                      ? '0 : head_reg[qidx] + HW'(1);
                    fill_reg[qidx] <= fill_reg[qidx] - FW'(1);
                end
                rrts_pkg::OP_WAKE:
                begin
                    if (st_rd == rrts_pkg::ST_SLEEPING)
                        status_reg[rd_idx] <= rrts_pkg::ST_READY;
                end
                default:
                    cur_reg <= cur_reg;
            endcase
        end
    end

    // per-request registers and staged result
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            rrts_pkg::OP_LOAD:
            begin
                cmd_reg      <= rrts_pkg::cmd_t'(command);
                tgt_reg      <= target_slot;
                qs_reg       <= queue_select;
                n_reg        <= '0;
                woken_reg    <= '0;
                res_code_reg <= rrts_pkg::RC_OK;
                res_slot_reg <= '0;
            end
            rrts_pkg::OP_STEP:
                n_reg <= n_reg + SW'(1);
            rrts_pkg::OP_FOUND:
            begin
                if (cmd_reg == rrts_pkg::CMD_SLEEP && q_full)
                    res_code_reg <= rrts_pkg::RC_FULL;
                else
                    res_slot_reg <= scan_idx;
            end
            rrts_pkg::OP_NOTFOUND:
                res_code_reg <= (cmd_reg == rrts_pkg::CMD_CREATE) ? rrts_pkg::RC_NOSLOT
                                                                  : rrts_pkg::RC_NONE;
            rrts_pkg::OP_TARGET:
            begin
                if (cmd_reg == rrts_pkg::CMD_YIELD_TO)
                begin
                    if (tgt_is_cur)
                        res_slot_reg <= cur_reg;
                    else if (!tgt_ok || st_rd != rrts_pkg::ST_READY)
                        res_code_reg <= rrts_pkg::RC_INVALID;
                    else
                        res_slot_reg <= rd_idx;
                end
                else if (!tgt_ok || st_rd == rrts_pkg::ST_EMPTY || tgt_is_cur)
                    res_code_reg <= rrts_pkg::RC_INVALID;
                else
                    res_slot_reg <= rd_idx;
            end
            rrts_pkg::OP_INVALID:
                res_code_reg <= rrts_pkg::RC_INVALID;
            rrts_pkg::OP_WAKE:
            begin
                if (st_rd == rrts_pkg::ST_SLEEPING)
                    woken_reg <= woken_reg + FW'(1);
            end
            rrts_pkg::OP_WAKE_END:
                res_code_reg <= (woken_reg == '0) ? rrts_pkg::RC_NONE : rrts_pkg::RC_OK;
            default:
                n_reg <= n_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_code_reg  <= res_code_reg;
            out_slot_reg  <= 4'(res_slot_reg);
            out_woken_reg <= 5'(woken_reg);
            out_run_reg   <= 4'(cur_reg);
        end
    end

    assign result_code  = out_code_reg;
    assign result_slot  = out_slot_reg;
    assign woken_count  = out_woken_reg;
    assign running_slot = out_run_reg;

endmodule
